[rtl/core/mlg_pkg.sv]
// Package: transaction types, register indexes, verdict codes and the mu-law expander.
`timescale 1ns / 1ps

package mlg_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 10;

  localparam logic [CfgIndexWidth-1:0] REG_STOP_AFTER = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_QUIET_MARGIN = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_FRAME_LEN = 2'd2;

  localparam logic [7:0] STOP_AFTER_RESET = 8'd50;
  localparam logic [6:0] QUIET_MARGIN_RESET = 7'd2;
  localparam logic [9:0] MAX_FRAME_LEN_RESET = 10'd960;

  localparam logic [2:0] V_DROP   = 3'd0;
  localparam logic [2:0] V_START  = 3'd1;
  localparam logic [2:0] V_PLAY   = 3'd2;
  localparam logic [2:0] V_STOP   = 3'd3;
  localparam logic [2:0] V_REJECT = 3'd4;

  localparam logic [7:0]  RUN_MAX = 8'hFF;
  localparam logic [15:0] MU_BIAS = 16'h0084;

  typedef struct packed {
    logic [7:0] mulaw_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               is_frame_end;
    logic [2:0]         verdict;
    logic               playing;
  } out_item_t;

  typedef struct packed {
    logic [7:0] stop_after_frames;
    logic [6:0] quiet_margin;
    logic [9:0] max_frame_len;
  } cfg_t;

  // One classified byte as handed from front to back.
  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               frame_end;
    logic               oversize;
    logic [9:0]         frame_count;
    logic [9:0]         quiet_count;
  } frame_info_t;

  function automatic logic signed [15:0] mu_decode(input logic [7:0] b);
    logic [7:0]  c;
    logic [15:0] base;
    logic [15:0] mag;
    c    = ~b;
    base = {9'd0, c[3:0], 3'd0} + MU_BIAS;
    mag  = (base << c[6:4]) - MU_BIAS;
    return c[7] ? $signed(16'd0 - mag) : $signed(mag);
  endfunction

endpackage

[rtl/core/mlg_front.sv]
// Front: mu-law decode, quiet test and per-frame length and quiet counters.
`timescale 1ns / 1ps

module mlg_front
  import mlg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output frame_info_t info
);

  logic [9:0]  frame_count;
  logic [9:0]  quiet_count;
  logic        oversize;
  logic [9:0]  frame_count_next;
  logic [9:0]  quiet_count_next;
  logic        oversize_next;
  logic [10:0] len_inc;
  logic        quiet;

  assign len_inc = {1'b0, frame_count} + 11'd1;
  assign quiet   = ((8'hFF - item.mulaw_byte) <= {1'b0, cfg.quiet_margin}) ||
                   (item.mulaw_byte <= {1'b0, cfg.quiet_margin});

  always_comb begin
    frame_count_next = frame_count;
    quiet_count_next = quiet_count;
    oversize_next    = oversize;
    if (!oversize) begin
      if (len_inc > {1'b0, cfg.max_frame_len}) begin
        oversize_next = 1'b1;
      end else begin
        frame_count_next = len_inc[9:0];
        if (quiet) begin
          quiet_count_next = quiet_count + 10'd1;
        end
      end
    end
  end

  assign info.pcm_sample  = mu_decode(item.mulaw_byte);
  assign info.frame_end   = item.frame_end;
  assign info.oversize    = oversize_next;
  assign info.frame_count = frame_count_next;
  assign info.quiet_count = quiet_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      quiet_count <= '0;
      oversize    <= 1'b0;
    end else if (accept) begin
      if (item.frame_end) begin
        frame_count <= '0;
        quiet_count <= '0;
        oversize    <= 1'b0;
      end else begin
        frame_count <= frame_count_next;
        quiet_count <= quiet_count_next;
        oversize    <= oversize_next;
      end
    end
  end

endmodule

[rtl/core/mlg_queue.sv]
// Small FIFO between front and back; push and pop may happen in the same cycle, but a push is refused while full.
`timescale 1ns / 1ps

module mlg_queue
  import mlg_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_info_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output frame_info_t head
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  frame_info_t         entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

endmodule

[rtl/core/mlg_back.sv]
// Back: silence decision, playback gate state and output register.
`timescale 1ns / 1ps

module mlg_back
  import mlg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_valid,
  input  frame_info_t entry,
  input  cfg_t        cfg,
  output logic        pop,
  output logic        dst_valid,
  input  logic        dst_stall,
  output out_item_t   dst_data
);

  logic       playing;
  logic [7:0] silent_run;
  logic       playing_next;
  logic [7:0] silent_run_next;
  logic [7:0] run_inc;
  logic [2:0] verdict;
  logic [13:0] quiet_x10;
  logic [13:0] len_x9;
  logic        silent;

  assign pop = entry_valid && (!dst_valid || !dst_stall);

  assign quiet_x10 = {1'b0, entry.quiet_count, 3'd0} + {3'd0, entry.quiet_count, 1'b0};
  assign len_x9    = {1'b0, entry.frame_count, 3'd0} + {4'd0, entry.frame_count};
  assign silent    = (quiet_x10 >= len_x9);
  assign run_inc   = (silent_run == RUN_MAX) ? silent_run : silent_run + 8'd1;

  always_comb begin
    playing_next    = playing;
    silent_run_next = silent_run;
    verdict         = V_DROP;
    if (entry.frame_end) begin
      priority if (entry.oversize) begin
        verdict = V_REJECT;
      end else if (!playing) begin
        if (!silent) begin
          playing_next    = 1'b1;
          silent_run_next = '0;
          verdict         = V_START;
        end
      end else if (silent) begin
        if (run_inc >= cfg.stop_after_frames) begin
          playing_next    = 1'b0;
          silent_run_next = '0;
          verdict         = V_STOP;
        end else begin
          silent_run_next = run_inc;
          verdict         = V_PLAY;
        end
      end else begin
        silent_run_next = '0;
        verdict         = V_PLAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing    <= 1'b0;
      silent_run <= '0;
      dst_valid  <= 1'b0;
    end else begin
      if (pop) begin
        playing    <= playing_next;
        silent_run <= silent_run_next;
        dst_valid  <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dst_data.pcm_sample   <= entry.pcm_sample;
      dst_data.is_frame_end <= entry.frame_end;
      dst_data.verdict      <= verdict;
      dst_data.playing      <= playing_next;
    end
  end

endmodule

[rtl/core/mulaw_playback_silence_gate.sv]
// Top level: mu-law playback decoder with frame silence gate.
//
//   channel | direction | handshake          | payload
//   src     | in        | src_valid/src_stall | in_item_t  (mulaw_byte, frame_end)
//   dst     | out       | dst_valid/dst_stall | out_item_t (pcm_sample, is_frame_end,
//           |           |                    |             verdict, playing)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while dst_stall is low; each result is registered.
// The front counters and the queue set the input side; the output register the other.
// src_stall rises only when the QUEUE_DEPTH-entry queue is full.
// rst is synchronous: gate idle, counters cleared, registers at their reset values.
// cfg_ready is always high; index 3 is ignored.
`timescale 1ns / 1ps

module mulaw_playback_silence_gate
  import mlg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     src_valid,
  output logic                     src_stall,
  input  in_item_t                 src_data,
  output logic                     dst_valid,
  input  logic                     dst_stall,
  output out_item_t                dst_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t        cfg;
  frame_info_t front_info;
  frame_info_t queue_head;
  logic        queue_full;
  logic        queue_not_empty;
  logic        queue_pop;
  logic        src_accept;

  assign cfg_ready  = 1'b1;
  assign src_stall  = queue_full;
  assign src_accept = src_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_after_frames <= STOP_AFTER_RESET;
      cfg.quiet_margin      <= QUIET_MARGIN_RESET;
      cfg.max_frame_len     <= MAX_FRAME_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STOP_AFTER:    cfg.stop_after_frames <= cfg_data[7:0];
        REG_QUIET_MARGIN:  cfg.quiet_margin      <= cfg_data[6:0];
        REG_MAX_FRAME_LEN: cfg.max_frame_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  mlg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (src_accept),
    .item   (src_data),
    .cfg    (cfg),
    .info   (front_info)
  );

  mlg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (src_accept),
    .push_data (front_info),
    .pop       (queue_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  mlg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (queue_not_empty),
    .entry       (queue_head),
    .cfg         (cfg),
    .pop         (queue_pop),
    .dst_valid   (dst_valid),
    .dst_stall   (dst_stall),
    .dst_data    (dst_data)
  );

endmodule

[rtl/core/mlg_checker.sv]
// Port-level checker for the silence gate, bound to the top level.
`timescale 1ns / 1ps

module mlg_checker
  import mlg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      dst_valid,
  input logic      dst_stall,
  input out_item_t dst_data
);

  assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("dst transaction changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_data.is_frame_end |-> dst_data.verdict == V_DROP)
    else $error("verdict set on a byte that does not end a frame");

  assert property (@(posedge clk) disable iff (rst)
    dst_valid && (dst_data.verdict == V_START || dst_data.verdict == V_PLAY)
      |-> dst_data.playing)
    else $error("start or play verdict with gate idle");

  assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.is_frame_end &&
      (dst_data.verdict == V_STOP || dst_data.verdict == V_DROP)
      |-> !dst_data.playing)
    else $error("stop or drop verdict with gate playing");

endmodule

bind mulaw_playback_silence_gate mlg_checker u_mlg_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);

[tb/mulaw_gate_checker.sv]
// Checker: watches the byte, result and register channels, predicts each result and compares.
`timescale 1ns / 1ps

module mulaw_gate_checker
  import mlg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     src_valid,
  input  logic                     src_stall,
  input  in_item_t                 src_data,
  input  logic                     dst_valid,
  input  logic                     dst_stall,
  input  out_item_t                dst_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output int unsigned              fail_count,
  output int unsigned              open_items
);

  // gate registers as the block should hold them
  int   stop_after;
  int   margin;
  int   max_len;

  // gate and frame state
  logic gate_open;
  int   quiet_run;
  int   frame_len;
  int   quiet_len;
  logic over_flag;

  out_item_t pending_results[$];
  out_item_t want;

  initial begin
    fail_count = 0;
    open_items = 0;
  end

  function automatic logic signed [15:0] expand_mulaw(input logic [7:0] code);
    logic [7:0] inv;
    int         mag;
    inv = ~code;
    mag = ((int'(inv[3:0]) * 8 + 132) << inv[6:4]) - 132;
    return inv[7] ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic bit is_quiet(input logic [7:0] b);
    return (255 - int'(b)) <= margin || int'(b) <= margin;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  task automatic gate_step(input in_item_t it, output out_item_t r);
    logic [2:0] v;
    bit         silent;
    v = V_DROP;
    if (!over_flag) begin
      if (frame_len + 1 > max_len) begin
        over_flag = 1'b1;
      end else begin
        frame_len++;
        if (is_quiet(it.mulaw_byte)) quiet_len++;
      end
    end
    if (it.frame_end) begin
      if (over_flag) begin
        v = V_REJECT;
      end else begin
        silent = quiet_len * 10 >= frame_len * 9;
        if (!gate_open) begin
          if (silent) begin
            v = V_DROP;
          end else begin
            gate_open = 1'b1;
            quiet_run = 0;
            v = V_START;
          end
        end else if (silent) begin
          if (quiet_run < 255) quiet_run++;
          if (quiet_run >= stop_after) begin
            gate_open = 1'b0;
            quiet_run = 0;
            v = V_STOP;
          end else begin
            v = V_PLAY;
          end
        end else begin
          quiet_run = 0;
          v = V_PLAY;
        end
      end
      frame_len = 0;
      quiet_len = 0;
      over_flag = 1'b0;
    end
    r.pcm_sample   = expand_mulaw(it.mulaw_byte);
    r.is_frame_end = it.frame_end;
    r.verdict      = v;
    r.playing      = gate_open;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stop_after = int'(STOP_AFTER_RESET);
      margin     = int'(QUIET_MARGIN_RESET);
      max_len    = int'(MAX_FRAME_LEN_RESET);
      gate_open  = 1'b0;
      quiet_run  = 0;
      frame_len  = 0;
      quiet_len  = 0;
      over_flag  = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STOP_AFTER:    stop_after = int'(cfg_data[7:0]);
          REG_QUIET_MARGIN:  margin = int'(cfg_data[6:0]);
          REG_MAX_FRAME_LEN: max_len = int'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (src_valid && !src_stall) begin
        gate_step(src_data, want);
        pending_results.push_back(want);
      end
      if (dst_valid && !dst_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected transaction", int'(dst_data.verdict), -1);
        end else begin
          want = pending_results.pop_front();
          if (dst_data.pcm_sample !== want.pcm_sample)
            flag_mismatch("pcm_sample", dst_data.pcm_sample, want.pcm_sample);
          if (dst_data.is_frame_end !== want.is_frame_end)
            flag_mismatch("is_frame_end", dst_data.is_frame_end, want.is_frame_end);
          if (dst_data.verdict !== want.verdict)
            flag_mismatch("verdict", dst_data.verdict, want.verdict);
          if (dst_data.playing !== want.playing)
            flag_mismatch("playing", dst_data.playing, want.playing);
        end
      end
    end
    open_items = pending_results.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, byte and register stimulus, result sink and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import mlg_pkg::*;

  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned PhaseItems = 130;
  localparam int unsigned HoldAt = 300;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned DrainCycles = 20;
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     src_valid;
  logic                     src_stall;
  in_item_t                 src_data;
  logic                     dst_valid;
  logic                     dst_stall;
  out_item_t                dst_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  int unsigned fail_count;
  int unsigned open_items;
  int unsigned tx_count;
  int unsigned rx_count;
  int          cur_margin;
  int          cur_max;

  mulaw_playback_silence_gate dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mulaw_gate_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_data   (src_data),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dst_data   (dst_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_items (open_items)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    int unsigned gap;
    gap = ((tx_count / 50) % 6 == 4) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= {b, fe};
    do @(posedge clk); while (src_stall);
    tx_count++;
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    do @(posedge clk); while (rx_count != tx_count);
  endtask

  task automatic write_regs(input logic [9:0] stop_v, input logic [9:0] margin_v,
                            input logic [9:0] max_v, input bit poke_unused);
    logic [CfgIndexWidth-1:0] idx[4];
    logic [CfgDataWidth-1:0]  val[4];
    int                       n;
    idx[0] = REG_STOP_AFTER;    val[0] = stop_v;
    idx[1] = REG_QUIET_MARGIN;  val[1] = margin_v;
    idx[2] = REG_MAX_FRAME_LEN; val[2] = max_v;
    idx[3] = REG_UNUSED;        val[3] = 10'($urandom_range(0, 1023));
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cur_margin = int'(margin_v[6:0]);
    cur_max    = int'(max_v);
  endtask

  function automatic logic [7:0] quiet_byte();
    int d;
    d = $urandom_range(0, cur_margin);
    return $urandom_range(0, 1) ? 8'(d) : 8'(255 - d);
  endfunction

  function automatic logic [7:0] loud_byte();
    if (cur_margin >= 127) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(cur_margin + 1, 254 - cur_margin));
  endfunction

  // nq < 0: unconstrained bytes; otherwise at least nq quiet bytes at random places
  task automatic send_frame(input int len, input int nq);
    int         left;
    logic [7:0] b;
    left = nq;
    for (int i = 0; i < len; i++) begin
      if (nq < 0) begin
        b = 8'($urandom_range(0, 255));
      end else if ($urandom_range(1, len - i) <= left) begin
        b = quiet_byte();
        left--;
      end else begin
        b = loud_byte();
      end
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    dst_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (dst_valid && !dst_stall) begin
        rx_count++;
        if (rx_count == HoldAt) wait_left = HoldCycles;
        else if ((rx_count / 50) % 6 == 1) wait_left = 0;
        else wait_left = $urandom_range(0, 7);
      end else if (dst_stall && wait_left != 0) begin
        wait_left--;
      end
      dst_stall <= (wait_left != 0);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int          phase;
    int unsigned phase_start;
    int          len;
    int          hi;
    int          nq;
    rst        = 1'b1;
    src_valid  = 1'b0;
    src_data   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_STOP_AFTER;
    cfg_data   = '0;
    tx_count   = 0;
    rx_count   = 0;
    cur_margin = int'(QUIET_MARGIN_RESET);
    cur_max    = int'(MAX_FRAME_LEN_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: drop, start, play, run cleared, 90% quiet frame
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
    // oversize reject, stop on first silent frame, full-length frame accepted
    write_regs(10'd1, 10'd2, 10'd3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h83, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h9A, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h2C, 1'b1);

    phase = 0;
    while (tx_count < ItemTarget) begin
      drain();
      case (phase)
        0: write_regs(10'd3, 10'd2, 10'd12, 1'b0);
        1: write_regs(10'd1, 10'd0, 10'd1, 1'b1);
        2: write_regs(10'd0, 10'd127, 10'd0, 1'b0);
        3: write_regs(10'd255, 10'd127, 10'd1023, 1'b0);
        4: write_regs(10'd2, 10'd64, 10'd20, 1'b0);
        5: write_regs(10'd4, 10'd10, 10'd960, 1'b0);
        6: write_regs(10'd1, 10'd5, 10'd8, 1'b0);
        default: write_regs(10'($urandom_range(0, 6)), 10'($urandom_range(0, 20)),
                            ($urandom_range(0, 7) == 0) ? 10'd1023
                                                         : 10'($urandom_range(0, 40)),
                            1'b0);
      endcase
      phase_start = tx_count;
      while (tx_count - phase_start < PhaseItems && tx_count < ItemTarget) begin
        hi  = (cur_max < 30) ? cur_max + 3 : 24;
        len = $urandom_range(1, hi);
        case ($urandom_range(0, 4))
          0, 1: nq = len;
          2: nq = 0;
          3: begin
            nq = (9 * len + 9) / 10;
            if ($urandom_range(0, 1) && nq > 0) nq--;
          end
          default: nq = -1;
        endcase
        send_frame(len, nq);
      end
      phase++;
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && open_items == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
